@@ hdl/sdf_pkg.sv @@
// Shared types, constants and decimal tables for the signed decimal formatter.
// Used by sdf_front, sdf_queue, sdf_back and signed_decimal_formatter.
`default_nettype none
package sdf_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned CharW      = 6;
  localparam int unsigned LenW       = 4;
  localparam int unsigned PosW       = 4;
  localparam int unsigned CmpW       = 34;
  localparam int unsigned MaxPos     = 9;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } sdf_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } sdf_state_e;

  function automatic logic [CmpW-1:0] pow10(input logic [PosW-1:0] pos);
    logic [CmpW-1:0] r;
    unique case (pos)
      4'd0:    r = 34'd1;
      4'd1:    r = 34'd10;
      4'd2:    r = 34'd100;
      4'd3:    r = 34'd1000;
      4'd4:    r = 34'd10000;
      4'd5:    r = 34'd100000;
      4'd6:    r = 34'd1000000;
      4'd7:    r = 34'd10000000;
      4'd8:    r = 34'd100000000;
      4'd9:    r = 34'd1000000000;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

  // c times ten to the pos, for c in 0..9
  function automatic logic [CmpW-1:0] pow10_mult(input logic [PosW-1:0] pos,
                                                 input logic [3:0]      c);
    logic [CmpW-1:0] p;
    p = pow10(pos);
    return CmpW'(p * CmpW'(c));
  endfunction

endpackage
`default_nettype wire

@@ hdl/sdf_front.sv @@
// Input stage: takes one integer per transfer, splits it into sign and magnitude.
// Depends on sdf_pkg.
`default_nettype none
module sdf_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [sdf_pkg::ValueW-1:0]  s_axis_tdata,
  output logic                             item_vld_o,
  input  wire logic                        item_rdy_i,
  output sdf_pkg::sdf_item_t               item_o
);

  logic               vld_q, vld_d;
  sdf_pkg::sdf_item_t item_q, item_d;
  logic               accept;

  assign s_axis_tready = !vld_q || item_rdy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d     = item_q;
    item_d.neg = s_axis_tdata[sdf_pkg::ValueW-1];
    item_d.mag = item_d.neg ? (sdf_pkg::ValueW'(0) - s_axis_tdata) : s_axis_tdata;
    if (accept) begin
      vld_d = 1'b1;
    end else if (item_rdy_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule
`default_nettype wire

@@ hdl/sdf_queue.sv @@
// Short first-in first-out queue of sign/magnitude items between front and back.
// Depends on sdf_pkg.
`default_nettype none
module sdf_queue #(
  parameter int unsigned Depth = sdf_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_vld_i,
  output logic               push_rdy_o,
  input  sdf_pkg::sdf_item_t push_item_i,
  output logic               pop_vld_o,
  input  wire logic          pop_rdy_i,
  output sdf_pkg::sdf_item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sdf_pkg::sdf_item_t store_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  assign push_rdy_o = cnt_q != CntW'(Depth);
  assign pop_vld_o  = cnt_q != '0;
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_rdy_i && pop_vld_o;
  assign pop_item_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sdf_back.sv @@
// Character sequencer: one ASCII character per cycle while out_rdy_i allows, most significant first,
// from the queued magnitude by subtracting multiples of powers of ten. Uses sdf_pkg.
`default_nettype none
module sdf_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       item_vld_i,
  output logic                            item_rdy_o,
  input  sdf_pkg::sdf_item_t              item_i,
  output logic                            out_vld_o,
  input  wire logic                       out_rdy_i,
  output logic [sdf_pkg::CharW-1:0]       out_char_o,
  output logic                            out_last_o,
  output logic [sdf_pkg::LenW-1:0]        out_len_o
);

  sdf_pkg::sdf_state_e             state_q, state_d;
  logic [sdf_pkg::ValueW-1:0]      rem_q, rem_d;
  logic [sdf_pkg::PosW-1:0]        pos_q, pos_d;
  logic [sdf_pkg::LenW-1:0]        len_q, len_d;
  logic                            out_vld_q, out_vld_d;
  logic [sdf_pkg::CharW-1:0]       out_char_q, out_char_d;
  logic                            out_last_q, out_last_d;
  logic [sdf_pkg::LenW-1:0]        out_len_q, out_len_d;
  logic                            slot_free, final_digit, pop;
  logic [sdf_pkg::LenW-1:0]        ndig;
  logic [3:0]                      digit;
  logic [sdf_pkg::CmpW-1:0]        sub_val;

  assign slot_free   = !out_vld_q || out_rdy_i;
  assign final_digit = (state_q == sdf_pkg::ST_DIGIT) && slot_free && (pos_q == '0);
  assign item_rdy_o  = (state_q == sdf_pkg::ST_IDLE) || final_digit;
  assign pop         = item_vld_i && item_rdy_o;

  always_comb begin
    ndig = sdf_pkg::LenW'(1);
    for (int k = 1; k <= int'(sdf_pkg::MaxPos); k++) begin
      if ({2'b00, item_i.mag} >= sdf_pkg::pow10(sdf_pkg::PosW'(k))) begin
        ndig = ndig + 1'b1;
      end
    end
  end

  always_comb begin
    digit = 4'd0;
    for (int c = 1; c <= 9; c++) begin
      if ({2'b00, rem_q} >= sdf_pkg::pow10_mult(pos_q, 4'(c))) begin
        digit = 4'(c);
      end
    end
    sub_val = sdf_pkg::pow10_mult(pos_q, digit);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdf_pkg::ST_IDLE: begin
        if (item_vld_i) begin
          state_d = item_i.neg ? sdf_pkg::ST_SIGN : sdf_pkg::ST_DIGIT;
        end
      end
      sdf_pkg::ST_SIGN: begin
        if (slot_free) begin
          state_d = sdf_pkg::ST_DIGIT;
        end
      end
      sdf_pkg::ST_DIGIT: begin
        if (final_digit) begin
          if (item_vld_i) begin
            state_d = item_i.neg ? sdf_pkg::ST_SIGN : sdf_pkg::ST_DIGIT;
          end else begin
            state_d = sdf_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rem_d      = rem_q;
    pos_d      = pos_q;
    len_d      = len_q;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    out_len_d  = out_len_q;
    out_vld_d  = out_rdy_i ? 1'b0 : out_vld_q;
    unique case (state_q)
      sdf_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_char_d = sdf_pkg::CharMinus;
          out_last_d = 1'b0;
          out_len_d  = len_q;
        end
      end
      sdf_pkg::ST_DIGIT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_char_d = sdf_pkg::CharZero + sdf_pkg::CharW'(digit);
          out_last_d = pos_q == '0;
          out_len_d  = len_q;
          rem_d      = rem_q - sub_val[sdf_pkg::ValueW-1:0];
          pos_d      = pos_q - 1'b1;
        end
      end
      default: ;
    endcase
    if (pop) begin
      rem_d = item_i.mag;
      pos_d = ndig - 1'b1;
      len_d = ndig + sdf_pkg::LenW'(item_i.neg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdf_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    len_q      <= len_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_len_q  <= out_len_d;
  end

  assign out_vld_o  = out_vld_q;
  assign out_char_o = out_char_q;
  assign out_last_o = out_last_q;
  assign out_len_o  = out_len_q;

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdf_pkg::ST_DIGIT) |->
      ({2'b00, rem_q} < sdf_pkg::pow10_mult(pos_q, 4'd9) + sdf_pkg::pow10(pos_q)))
    else $error("remainder exceeds current digit position");

  a_sign_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdf_pkg::ST_SIGN) |-> (len_q >= sdf_pkg::LenW'(2)))
    else $error("sign pending with no digits");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_char_q == sdf_pkg::CharMinus) |-> !out_last_q)
    else $error("minus sign marked as last character");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdf_pkg::ST_DIGIT) |-> (pos_q <= sdf_pkg::PosW'(sdf_pkg::MaxPos)))
    else $error("digit position out of range");

endmodule
`default_nettype wire

@@ hdl/signed_decimal_formatter.sv @@
// Top level of the signed decimal formatter: front stage, item queue, character
// sequencer. Depends on sdf_pkg, sdf_front, sdf_queue and sdf_back.
//
// Channel  Dir  Fields (low bit up)
// s_axis   in   tdata: value[31:0]
// m_axis   out  tdata: text_char[5:0], text_length[9:6], zeros[15:10]; tlast: is_last
//
// One character leaves per cycle while m_axis_tready is high; an integer's text
// has 1 to 11 characters, and the output register holds one character at a time.
// Data path: front register, queue store, sequencer, then output register.
// Reset clears all valid flags and the sequencer state; no clearing pass.
// m_axis_tready low holds the output; the queue keeps taking inputs until full.
`default_nettype none
module signed_decimal_formatter #(
  parameter int unsigned QueueDepth = sdf_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // value[31:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // text_char[5:0], text_length[9:6], zero pad
  output logic             m_axis_tlast
);

  sdf_pkg::sdf_item_t              front_item, queue_item;
  logic                            front_vld, front_rdy, queue_vld, queue_rdy;
  logic [sdf_pkg::CharW-1:0]       text_char;
  logic [sdf_pkg::LenW-1:0]        text_length;

  sdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_vld_o    (front_vld),
    .item_rdy_i    (front_rdy),
    .item_o        (front_item)
  );

  sdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (front_vld),
    .push_rdy_o  (front_rdy),
    .push_item_i (front_item),
    .pop_vld_o   (queue_vld),
    .pop_rdy_i   (queue_rdy),
    .pop_item_o  (queue_item)
  );

  sdf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (queue_vld),
    .item_rdy_o (queue_rdy),
    .item_i     (queue_item),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_char_o (text_char),
    .out_last_o (m_axis_tlast),
    .out_len_o  (text_length)
  );

  assign m_axis_tdata = {6'd0, text_length, text_char};

endmodule
`default_nettype wire
